// File: rtl/core/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg : shared types for the minimax path unit
// Beat formats, distance unit request and response, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mmp_pkg;

  localparam int COORD_W = 16;
  localparam int MAG_W   = 16;
  localparam int SQ_W    = 32;
  localparam int DIST_W  = 33;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      last_point;
  } in_beat_t;

  typedef struct packed {
    logic [DIST_W-1:0] bottleneck_sq;
    logic              valid_res;
    logic              overflow;
  } out_beat_t;

  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } dist_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] sq_len;
  } dist_rsp_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_SQX,
    D_SQY,
    D_SUM,
    D_DONE
  } dist_state_t;

  typedef enum logic [3:0] {
    T_LOAD,
    T_MARK,
    T_MARK_WAIT,
    T_UPD_RD,
    T_UPD_ST,
    T_UPD_WAIT,
    T_SCAN_RD,
    T_SCAN_CMP,
    T_RES_RD,
    T_EMIT
  } top_state_t;

endpackage

`default_nettype wire

// File: rtl/core/minimax_path_prim_unit.sv
// ----------------------------------------------------------------------------
// minimax_path_prim_unit : minimax path between the first two points
// Dense Prim over stored points, largest tree-path edge tracked per point.
// ----------------------------------------------------------------------------
// Input beats carry one signed point each; last_point closes the set. Points
// load at one per cycle while in_ready is high. Points beyond MAX_POINTS are
// dropped and reported through overflow.
// After the closing beat in_ready falls while the sequencer runs Prim from
// point 0: each step marks the newest tree point, relaxes every outside point
// through the shared squared-distance unit (a point already in the tree is
// skipped without a request), then scans the work memories for the cheapest
// outside point. The pace is set by the single squaring multiplier and the
// one read port of each work memory. Sets of fewer than two points skip Prim
// and go from the load state straight to the emit state.
// The result beat sits in an output register until out_ready takes it; a new
// set may load meanwhile, and the next result waits for that register to free.
// Reset empties the point store and clears the output valid flag; the memories
// need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module minimax_path_prim_unit #(
  parameter int MAX_POINTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mmp_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mmp_pkg::out_beat_t     out_data
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);

  mmp_pkg::top_state_t state, state_next;

  logic [CW-1:0] count, count_next, added, added_next;
  logic          dropped, dropped_next;
  logic [IW-1:0] i, i_next, u, u_next;
  logic          first, first_next, found, found_next, vflag, vflag_next;
  logic signed [mmp_pkg::COORD_W-1:0] ux, ux_next, uy, uy_next;
  logic [mmp_pkg::DIST_W-1:0] pu, pu_next, bmin, bmin_next;
  logic          res_valid, res_valid_next;
  mmp_pkg::out_beat_t res, res_next;

  logic signed [mmp_pkg::COORD_W-1:0] x_mem [MAX_POINTS];
  logic signed [mmp_pkg::COORD_W-1:0] y_mem [MAX_POINTS];
  logic [mmp_pkg::DIST_W-1:0] best_mem [MAX_POINTS];
  logic [mmp_pkg::DIST_W-1:0] path_mem [MAX_POINTS];
  logic                       tree_mem [MAX_POINTS];

  logic signed [mmp_pkg::COORD_W-1:0] rd_x, rd_y;
  logic [mmp_pkg::DIST_W-1:0] rd_best, rd_path, path_wd;
  logic          rd_tree;
  logic          xy_we, bp_we, tree_we, tree_wd;
  logic [IW-1:0] xy_ra, path_ra, tree_wa;
  logic          i_last, upd_adv;
  logic          dstart;

  mmp_pkg::dist_req_t dreq;
  mmp_pkg::dist_rsp_t drsp;

  mmp_dist_unit u_dist (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign in_ready  = (state == mmp_pkg::T_LOAD);
  assign out_valid = res_valid;
  assign out_data  = res;

  assign i_last  = (CW'(i) == count - CW'(1));
  assign xy_ra   = (state == mmp_pkg::T_MARK) ? u : i;
  assign path_wd = (drsp.sq_len > pu) ? drsp.sq_len : pu;

  always_comb begin
    priority if (state == mmp_pkg::T_MARK) begin
      path_ra = u;
    end else if (state == mmp_pkg::T_RES_RD || state == mmp_pkg::T_EMIT) begin
      path_ra = IW'(1);
    end else begin
      path_ra = i;
    end
  end

  assign dreq.start = dstart;
  assign dreq.ax    = ux;
  assign dreq.ay    = uy;
  assign dreq.bx    = rd_x;
  assign dreq.by    = rd_y;

  always_ff @(posedge clk) begin
    if (xy_we) begin
      x_mem[count[IW-1:0]] <= in_data.px;
      y_mem[count[IW-1:0]] <= in_data.py;
    end
    rd_x <= x_mem[xy_ra];
    rd_y <= y_mem[xy_ra];
  end

  always_ff @(posedge clk) begin
    if (bp_we) begin
      best_mem[i] <= drsp.sq_len;
      path_mem[i] <= path_wd;
    end
    rd_best <= best_mem[i];
    rd_path <= path_mem[path_ra];
  end

  always_ff @(posedge clk) begin
    if (tree_we) tree_mem[tree_wa] <= tree_wd;
    rd_tree <= tree_mem[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmp_pkg::T_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
      added     <= '0;
      found     <= 1'b0;
      first     <= 1'b0;
    end else begin
      count     <= count_next;
      dropped   <= dropped_next;
      res_valid <= res_valid_next;
      added     <= added_next;
      found     <= found_next;
      first     <= first_next;
    end
  end

  always_ff @(posedge clk) begin
    i     <= i_next;
    u     <= u_next;
    ux    <= ux_next;
    uy    <= uy_next;
    pu    <= pu_next;
    bmin  <= bmin_next;
    vflag <= vflag_next;
    res   <= res_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    dropped_next   = dropped;
    added_next     = added;
    i_next         = i;
    u_next         = u;
    first_next     = first;
    found_next     = found;
    ux_next        = ux;
    uy_next        = uy;
    pu_next        = pu;
    bmin_next      = bmin;
    vflag_next     = vflag;
    res_valid_next = res_valid;
    res_next       = res;
    xy_we          = 1'b0;
    bp_we          = 1'b0;
    tree_we        = 1'b0;
    tree_wa        = i;
    tree_wd        = 1'b0;
    dstart         = 1'b0;
    upd_adv        = 1'b0;

    if (res_valid && out_ready) res_valid_next = 1'b0;

    unique case (state)
      mmp_pkg::T_LOAD: begin
        if (in_valid) begin
          if (count < CW'(MAX_POINTS)) begin
            xy_we      = 1'b1;
            count_next = count + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (in_data.last_point) begin
            vflag_next = (count_next >= CW'(2));
            u_next     = '0;
            first_next = 1'b1;
            added_next = '0;
            state_next = vflag_next ? mmp_pkg::T_MARK : mmp_pkg::T_EMIT;
          end
        end
      end
      mmp_pkg::T_MARK: begin
        tree_we    = 1'b1;
        tree_wa    = u;
        tree_wd    = 1'b1;
        state_next = mmp_pkg::T_MARK_WAIT;
      end
      mmp_pkg::T_MARK_WAIT: begin
        ux_next = rd_x;
        uy_next = rd_y;
        pu_next = first ? '0 : rd_path;
        if (added == count - CW'(1)) begin
          state_next = mmp_pkg::T_RES_RD;
        end else begin
          i_next     = IW'(1);
          state_next = mmp_pkg::T_UPD_RD;
        end
      end
      mmp_pkg::T_UPD_RD: state_next = mmp_pkg::T_UPD_ST;
      mmp_pkg::T_UPD_ST: begin
        if (!first && rd_tree) begin
          upd_adv = 1'b1;
        end else begin
          dstart     = 1'b1;
          state_next = mmp_pkg::T_UPD_WAIT;
        end
      end
      mmp_pkg::T_UPD_WAIT: begin
        if (drsp.done) begin
          bp_we   = first || (drsp.sq_len < rd_best);
          tree_we = first;
          upd_adv = 1'b1;
        end
      end
      mmp_pkg::T_SCAN_RD: state_next = mmp_pkg::T_SCAN_CMP;
      mmp_pkg::T_SCAN_CMP: begin
        if (!rd_tree && (!found || rd_best < bmin)) begin
          u_next     = i;
          bmin_next  = rd_best;
          found_next = 1'b1;
        end
        if (i_last) begin
          added_next = added + CW'(1);
          state_next = mmp_pkg::T_MARK;
        end else begin
          i_next     = i + IW'(1);
          state_next = mmp_pkg::T_SCAN_RD;
        end
      end
      mmp_pkg::T_RES_RD: state_next = mmp_pkg::T_EMIT;
      mmp_pkg::T_EMIT: begin
        if (!res_valid || out_ready) begin
          res_valid_next         = 1'b1;
          res_next.bottleneck_sq = vflag ? rd_path : '0;
          res_next.valid_res     = vflag;
          res_next.overflow      = dropped;
          count_next             = '0;
          dropped_next           = 1'b0;
          state_next             = mmp_pkg::T_LOAD;
        end
      end
      default: state_next = mmp_pkg::T_LOAD;
    endcase

    if (upd_adv) begin
      if (i_last) begin
        first_next = 1'b0;
        found_next = 1'b0;
        i_next     = IW'(1);
        state_next = mmp_pkg::T_SCAN_RD;
      end else begin
        i_next     = i + IW'(1);
        state_next = mmp_pkg::T_UPD_RD;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == mmp_pkg::T_UPD_WAIT)
    else $error("distance result arrived outside the relax wait");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_scan_found: assert property (@(posedge clk) disable iff (rst)
    (state == mmp_pkg::T_MARK && added != '0) |-> found)
    else $error("scan closed without an outside point");
`endif

endmodule

`default_nettype wire

// File: rtl/core/mmp_dist_unit.sv
// ----------------------------------------------------------------------------
// mmp_dist_unit : squared Euclidean distance unit
// One squaring multiplier used twice per request, sum registered at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_dist_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mmp_pkg::dist_req_t req,
  output mmp_pkg::dist_rsp_t      rsp
);

  mmp_pkg::dist_state_t state, state_next;

  logic signed [mmp_pkg::COORD_W:0] dxs, dys;
  logic        [mmp_pkg::COORD_W:0] dxm, dym;
  logic        [mmp_pkg::MAG_W-1:0] adx, ady, mop;
  logic        [mmp_pkg::SQ_W-1:0]  prod, sqx, sqy;
  logic        [mmp_pkg::DIST_W-1:0] dsum;

  assign dxs = {req.ax[mmp_pkg::COORD_W-1], req.ax} - {req.bx[mmp_pkg::COORD_W-1], req.bx};
  assign dys = {req.ay[mmp_pkg::COORD_W-1], req.ay} - {req.by[mmp_pkg::COORD_W-1], req.by};
  assign dxm = dxs[mmp_pkg::COORD_W] ? ((mmp_pkg::COORD_W+1)'(0) - dxs) : dxs;
  assign dym = dys[mmp_pkg::COORD_W] ? ((mmp_pkg::COORD_W+1)'(0) - dys) : dys;

  assign mop  = (state == mmp_pkg::D_SQX) ? adx : ady;
  assign prod = mmp_pkg::SQ_W'(mop) * mmp_pkg::SQ_W'(mop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmp_pkg::D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mmp_pkg::D_IDLE: if (req.start) state_next = mmp_pkg::D_SQX;
      mmp_pkg::D_SQX:  state_next = mmp_pkg::D_SQY;
      mmp_pkg::D_SQY:  state_next = mmp_pkg::D_SUM;
      mmp_pkg::D_SUM:  state_next = mmp_pkg::D_DONE;
      mmp_pkg::D_DONE: state_next = mmp_pkg::D_IDLE;
      default:         state_next = mmp_pkg::D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == mmp_pkg::D_IDLE && req.start) begin
      adx <= dxm[mmp_pkg::MAG_W-1:0];
      ady <= dym[mmp_pkg::MAG_W-1:0];
    end
    if (state == mmp_pkg::D_SQX) sqx <= prod;
    if (state == mmp_pkg::D_SQY) sqy <= prod;
    if (state == mmp_pkg::D_SUM) dsum <= mmp_pkg::DIST_W'(sqx) + mmp_pkg::DIST_W'(sqy);
  end

  assign rsp.done   = (state == mmp_pkg::D_DONE);
  assign rsp.sq_len = dsum;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench : minimax path unit
// Streams point sets into the unit and rebuilds each set alongside. On every
// closing beat a dense Prim walk from point 0 predicts the largest hop on the
// tree path to point 1, together with the valid and overflow flags. Result
// beats are checked field by field in order. The run covers directed corner
// sets, many small random sets, one set past capacity and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CAP       = 256;
  localparam int ITEMS     = 1650;
  localparam int MAX_GAP   = 17;
  localparam int HOLD_AT   = 30;
  localparam int HOLD_LEN  = 4000;
  localparam int BIG_SET   = CAP + 4;

  typedef enum int {
    COORD_FULL,
    COORD_GRID,
    COORD_EDGE
  } coord_mode_t;

  class minimax_scoreboard;
    logic signed [mmp_pkg::COORD_W-1:0] xs [CAP];
    logic signed [mmp_pkg::COORD_W-1:0] ys [CAP];
    int                                 held;
    bit                                 lost;
    mmp_pkg::out_beat_t                 expected_bottlenecks [$];
    int                                 mismatches;

    function new();
      held = 0;
      lost = 0;
      mismatches = 0;
    endfunction

    function longint hop_sq(int a, int b);
      longint dx;
      longint dy;
      dx = longint'(xs[a]) - longint'(xs[b]);
      dy = longint'(ys[a]) - longint'(ys[b]);
      return dx * dx + dy * dy;
    endfunction

    function mmp_pkg::out_beat_t minimax_of_set();
      mmp_pkg::out_beat_t r;
      longint    best [CAP];
      longint    worst [CAP];
      bit        joined [CAP];
      int        u;
      bit        found;
      longint    d;
      r = '0;
      r.valid_res = (held >= 2);
      r.overflow  = lost;
      if (held >= 2) begin
        foreach (joined[i]) joined[i] = 1'b0;
        joined[0] = 1'b1;
        for (int i = 1; i < held; i++) begin
          best[i]  = hop_sq(0, i);
          worst[i] = best[i];
        end
        for (int step = 1; step < held; step++) begin
          u = 0;
          found = 1'b0;
          for (int i = 1; i < held; i++) begin
            if (!joined[i] && (!found || best[i] < best[u])) begin
              u = i;
              found = 1'b1;
            end
          end
          if (!found) break;
          joined[u] = 1'b1;
          for (int i = 1; i < held; i++) begin
            if (!joined[i]) begin
              d = hop_sq(u, i);
              if (d < best[i]) begin
                best[i]  = d;
                worst[i] = (d > worst[u]) ? d : worst[u];
              end
            end
          end
        end
        r.bottleneck_sq = worst[1][mmp_pkg::DIST_W-1:0];
      end
      return r;
    endfunction

    function void note_point(mmp_pkg::in_beat_t b);
      if (held < CAP) begin
        xs[held] = b.px;
        ys[held] = b.py;
        held++;
      end else begin
        lost = 1'b1;
      end
      if (b.last_point) begin
        expected_bottlenecks.insert(expected_bottlenecks.size(), minimax_of_set());
        held = 0;
        lost = 1'b0;
      end
    endfunction

    function void check_result(mmp_pkg::out_beat_t got);
      mmp_pkg::out_beat_t want;
      if (expected_bottlenecks.size() == 0) begin
        $error("result beat with none pending: bottleneck_sq %0d valid_res %0d overflow %0d",
               got.bottleneck_sq, got.valid_res, got.overflow);
        mismatches++;
        return;
      end
      want = expected_bottlenecks.pop_front();
      if (got.bottleneck_sq !== want.bottleneck_sq) begin
        $error("bottleneck_sq: expected %0d, got %0d", want.bottleneck_sq, got.bottleneck_sq);
        mismatches++;
      end
      if (got.valid_res !== want.valid_res) begin
        $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_bottlenecks.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  mmp_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_ready;
  mmp_pkg::out_beat_t out_data;

  minimax_scoreboard sb;
  bit                calm;
  int                points_sent;
  int                results_seen;

  minimax_path_prim_unit #(
    .MAX_POINTS(CAP)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_xy(int x, int y, bit last);
    mmp_pkg::in_beat_t b;
    int                gap;
    b.px = x[mmp_pkg::COORD_W-1:0];
    b.py = y[mmp_pkg::COORD_W-1:0];
    b.last_point = last;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_point(b);
    points_sent++;
  endtask

  function automatic int pick_coord(coord_mode_t mode);
    int edges [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    unique case (mode)
      COORD_GRID: return $urandom_range(0, 8) - 4;
      COORD_EDGE: return edges[$urandom_range(0, 6)];
      default:    return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  task automatic send_set(int size, coord_mode_t mode);
    for (int k = 0; k < size; k++) begin
      send_xy(pick_coord(mode), pick_coord(mode), k == size - 1);
    end
  endtask

  initial begin
    coord_mode_t mode;
    int          size;
    bit          big_done;
    sb = new();
    calm = 1'b0;
    points_sent = 0;
    big_done = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone point, widest hop, coincident points
    send_xy(0, 0, 1'b1);
    send_xy(-32768, -32768, 1'b0);
    send_xy(32767, 32767, 1'b1);
    send_xy(32767, -32768, 1'b0);
    send_xy(32767, -32768, 1'b1);
    // chain on a line: path goes through the middle points
    send_xy(0, 0, 1'b0);
    send_xy(30, 0, 1'b0);
    send_xy(10, 0, 1'b0);
    send_xy(20, 0, 1'b1);
    // square: equal edges, lowest index wins
    send_xy(0, 0, 1'b0);
    send_xy(5, 0, 1'b0);
    send_xy(0, 5, 1'b0);
    send_xy(5, 5, 1'b1);
    // opposite corners through the origin
    send_xy(-32768, 32767, 1'b0);
    send_xy(32767, -32768, 1'b0);
    send_xy(0, 0, 1'b1);
    send_xy(-1, -1, 1'b0);
    send_xy(21845, -21846, 1'b1);

    while (points_sent < ITEMS) begin
      calm = ($urandom_range(0, 7) == 0);
      mode = coord_mode_t'($urandom_range(0, 2));
      if (!big_done && points_sent >= 700) begin
        calm = 1'b1;
        size = BIG_SET;
        mode = COORD_FULL;
        big_done = 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        size = 1;
      end else begin
        size = $urandom_range(2, 14);
      end
      send_set(size, mode);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int stall;
    results_seen = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (results_seen == HOLD_AT) stall = HOLD_LEN;
      else stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
      results_seen++;
    end
  end

endmodule

// File: filelist.f
rtl/core/mmp_pkg.sv
rtl/core/mmp_dist_unit.sv
rtl/core/minimax_path_prim_unit.sv
verif/testbench.sv
